// ===== hw/rtl/abnr_pkg.sv =====
// abnr_pkg: shared widths, command codes, queue entry and result types
// for the area border neighbor runs block; no dependencies
package abnr_pkg;

    localparam int COORD_W     = 4;
    localparam int SIZE_W      = 5;
    localparam int ID_W        = 9;
    localparam int NB_W        = 8;
    localparam int COUNT_W     = 12;
    localparam int TOTAL_W     = 6;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;

    localparam int GRID_SIDE_DEF = 16;
    localparam int FIELD_LIMIT   = 16;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX       = COUNT_W'(4095);
    localparam logic [SIZE_W-1:0]  GRID_SIZE_RESET = SIZE_W'(16);

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b1;

    typedef enum logic [1:0] {
        SIDE_TOP,
        SIDE_BOTTOM,
        SIDE_LEFT,
        SIDE_RIGHT
    } side_t;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_BUILD,
        OP_CLEAR
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_SUM
    } back_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic [COORD_W-1:0]        pos_x;
        logic [COORD_W-1:0]        pos_y;
        logic signed [ID_W-1:0]    cell_value;
        logic [SIZE_W-1:0]         area_width;
        logic [SIZE_W-1:0]         area_height;
    } cmd_item_t;

    typedef struct packed {
        op_t                       op;
        logic [COORD_W-1:0]        pos_x;
        logic [COORD_W-1:0]        pos_y;
        logic signed [ID_W-1:0]    value;
        logic [SIZE_W-1:0]         width;
        logic [SIZE_W-1:0]         height;
        logic [3:0]                sides;
    } queue_entry_t;

    typedef struct packed {
        logic                      is_summary;
        logic [COORD_W-1:0]        edge_x;
        logic [COORD_W-1:0]        edge_y;
        logic [SIZE_W-1:0]         edge_w;
        logic [SIZE_W-1:0]         edge_h;
        logic [NB_W-1:0]           neighbor_id;
        logic [COUNT_W-1:0]        first_edge;
        logic [TOTAL_W-1:0]        edge_total;
        logic                      last;
    } result_t;

endpackage

// ===== hw/rtl/abnr_if.sv =====
// abnr_cmd_if and abnr_result_if: valid/ready channels for command beats
// and result beats; depends on abnr_pkg
interface abnr_cmd_if;
    import abnr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       command;
    logic [COORD_W-1:0]     pos_x;
    logic [COORD_W-1:0]     pos_y;
    logic signed [ID_W-1:0] cell_value;
    logic [SIZE_W-1:0]      area_width;
    logic [SIZE_W-1:0]      area_height;

    modport source (
        output valid, command, pos_x, pos_y, cell_value, area_width, area_height,
        input  ready
    );
    modport sink (
        input  valid, command, pos_x, pos_y, cell_value, area_width, area_height,
        output ready
    );
endinterface

interface abnr_result_if;
    import abnr_pkg::*;

    logic               valid;
    logic               ready;
    logic               is_summary;
    logic [COORD_W-1:0] edge_x;
    logic [COORD_W-1:0] edge_y;
    logic [SIZE_W-1:0]  edge_w;
    logic [SIZE_W-1:0]  edge_h;
    logic [NB_W-1:0]    neighbor_id;
    logic [COUNT_W-1:0] first_edge;
    logic [TOTAL_W-1:0] edge_total;
    logic               last;

    modport source (
        output valid, is_summary, edge_x, edge_y, edge_w, edge_h, neighbor_id,
               first_edge, edge_total, last,
        input  ready
    );
    modport sink (
        input  valid, is_summary, edge_x, edge_y, edge_w, edge_h, neighbor_id,
               first_edge, edge_total, last,
        output ready
    );
endinterface

// ===== hw/rtl/area_border_neighbor_runs.sv =====
// area_border_neighbor_runs: top level, front decode, command queue and
// scan back end; depends on abnr_pkg, abnr_if, abnr_front, abnr_queue, abnr_back
//
//   channel     dir   handshake       beat
//   cmd_ch      in    valid/ready     one command: write cell, build, clear
//   result_ch   out   valid/ready     one edge or the closing summary
//   cfg         in    cfg_we          grid_cols (0) or grid_rows (1)
//
// write and clear: taken by the back end straight from the queue while idle
// build: one grid memory read per border cell, a close step per scanned
// side to close its last run, plus the load and summary steps
// the single read port of the grid memory sets the scan rate
// reset clears queue, sequencer, edge count; sets grid size to 16; keeps grid cells
// result stalls hold the scan; the queue keeps accepting commands until full
module area_border_neighbor_runs #(
    parameter int GRID_SIDE = abnr_pkg::GRID_SIDE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [abnr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [abnr_pkg::CFG_DATA_W-1:0] cfg_data,
    abnr_cmd_if.sink                        cmd_ch,
    abnr_result_if.source                   result_ch
);
    import abnr_pkg::*;

    cmd_item_t    in_item;
    queue_entry_t push_entry, pop_entry;
    logic         push_valid, push_ready, pop_valid, pop_ready;
    result_t      res;

    assign in_item.command     = cmd_ch.command;
    assign in_item.pos_x       = cmd_ch.pos_x;
    assign in_item.pos_y       = cmd_ch.pos_y;
    assign in_item.cell_value  = cmd_ch.cell_value;
    assign in_item.area_width  = cmd_ch.area_width;
    assign in_item.area_height = cmd_ch.area_height;

    abnr_front #(
        .GRID_SIDE (GRID_SIDE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (cmd_ch.valid),
        .in_ready   (cmd_ch.ready),
        .in_item    (in_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    abnr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    abnr_back #(
        .GRID_SIDE (GRID_SIDE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (pop_valid),
        .q_ready   (pop_ready),
        .q_entry   (pop_entry),
        .res_valid (result_ch.valid),
        .res_ready (result_ch.ready),
        .res       (res)
    );

    assign result_ch.is_summary  = res.is_summary;
    assign result_ch.edge_x      = res.edge_x;
    assign result_ch.edge_y      = res.edge_y;
    assign result_ch.edge_w      = res.edge_w;
    assign result_ch.edge_h      = res.edge_h;
    assign result_ch.neighbor_id = res.neighbor_id;
    assign result_ch.first_edge  = res.first_edge;
    assign result_ch.edge_total  = res.edge_total;
    assign result_ch.last        = res.last;

endmodule

// ===== hw/rtl/abnr_front.sv =====
// abnr_front: grid size registers, command decode and rectangle clipping
// into queue entries; depends on abnr_pkg
module abnr_front #(
    parameter int GRID_SIDE = abnr_pkg::GRID_SIDE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [abnr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [abnr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  abnr_pkg::cmd_item_t                 in_item,
    output logic                                push_valid,
    input  logic                                push_ready,
    output abnr_pkg::queue_entry_t              push_entry
);
    import abnr_pkg::*;

    localparam int LIM = (GRID_SIDE < FIELD_LIMIT) ? GRID_SIDE : FIELD_LIMIT;
    localparam logic [SIZE_W-1:0] LIM_SIZE = SIZE_W'(LIM);

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > LIM_SIZE)
            r = LIM_SIZE;
        else
            r = v;
        return r;
    endfunction

    logic [SIZE_W-1:0] cols_reg, cols_next;
    logic [SIZE_W-1:0] rows_reg, rows_next;

    logic [SIZE_W-1:0] cols, rows, px5, py5, avail_w, avail_h, w_clip, h_clip;
    logic              in_grid, area_ok, keep;

    always_comb
    begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_COLS: cols_next = cfg_data;
                CFG_GRID_ROWS: rows_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= GRID_SIZE_RESET;
            rows_reg <= GRID_SIZE_RESET;
        end
        else
        begin
            cols_reg <= cols_next;
            rows_reg <= rows_next;
        end
    end

    always_comb
    begin
        cols    = clamp_size(cols_reg);
        rows    = clamp_size(rows_reg);
        px5     = {1'b0, in_item.pos_x};
        py5     = {1'b0, in_item.pos_y};
        in_grid = (px5 < cols) && (py5 < rows);
        avail_w = cols - px5;
        avail_h = rows - py5;
        w_clip  = (in_item.area_width > avail_w) ? avail_w : in_item.area_width;
        h_clip  = (in_item.area_height > avail_h) ? avail_h : in_item.area_height;
        area_ok = in_grid && (in_item.area_width != '0) && (in_item.area_height != '0);

        push_entry.op     = OP_WRITE;
        push_entry.pos_x  = in_item.pos_x;
        push_entry.pos_y  = in_item.pos_y;
        push_entry.value  = in_item.cell_value;
        push_entry.width  = w_clip;
        push_entry.height = h_clip;
        push_entry.sides[SIDE_TOP]    = area_ok && (in_item.pos_y != '0);
        push_entry.sides[SIDE_BOTTOM] = area_ok && ((py5 + h_clip) < rows);
        push_entry.sides[SIDE_LEFT]   = area_ok && (in_item.pos_x != '0);
        push_entry.sides[SIDE_RIGHT]  = area_ok && ((px5 + w_clip) < cols);

        case (in_item.command)
            CMD_WRITE:
            begin
                push_entry.op = OP_WRITE;
                keep = in_grid;
            end
            CMD_BUILD:
            begin
                push_entry.op = OP_BUILD;
                keep = 1'b1;
            end
            CMD_CLEAR:
            begin
                push_entry.op = OP_CLEAR;
                keep = 1'b1;
            end
            default: keep = 1'b0;
        endcase

        in_ready   = push_ready;
        push_valid = in_valid && keep;
    end

endmodule

// ===== hw/rtl/abnr_queue.sv =====
// abnr_queue: short fifo of decoded commands between front and back
// depends on abnr_pkg
module abnr_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push_valid,
    output logic                    push_ready,
    input  abnr_pkg::queue_entry_t  push_entry,
    output logic                    pop_valid,
    input  logic                    pop_ready,
    output abnr_pkg::queue_entry_t  pop_entry
);
    import abnr_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(QUEUE_DEPTH);

    queue_entry_t      slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic              do_push, do_pop;

    always_comb
    begin
        push_ready  = (fill_reg != FULL_FILL);
        pop_valid   = (fill_reg != '0);
        pop_entry   = slot_reg[rd_ptr_reg];
        do_push     = push_valid && push_ready;
        do_pop      = pop_valid && pop_ready;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            fill_next = fill_reg + FW'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - FW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== hw/rtl/abnr_back.sv =====
// abnr_back: grid memory, border scan sequencer, run tracking, edge count
// and result register; depends on abnr_pkg
module abnr_back #(
    parameter int GRID_SIDE = abnr_pkg::GRID_SIDE_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  abnr_pkg::queue_entry_t  q_entry,
    output logic                    res_valid,
    input  logic                    res_ready,
    output abnr_pkg::result_t       res
);
    import abnr_pkg::*;

    localparam int LIM   = (GRID_SIDE < FIELD_LIMIT) ? GRID_SIDE : FIELD_LIMIT;
    localparam int DEPTH = LIM * LIM;
    localparam int AW    = $clog2(DEPTH);

    logic signed [ID_W-1:0] grid_mem [DEPTH];

    back_state_t            state_reg, state_next;
    logic [COORD_W-1:0]     cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [SIZE_W-1:0]      cur_w_reg, cur_w_next, cur_h_reg, cur_h_next;
    logic [3:0]             mask_reg, mask_next;
    logic [COORD_W-1:0]     idx_reg, idx_next;
    logic                   d_valid_reg, d_valid_next;
    side_t                  d_side_reg, d_side_next;
    logic [COORD_W-1:0]     d_idx_reg, d_idx_next;
    logic                   d_last_reg, d_last_next;
    logic signed [ID_W-1:0] rd_data_reg;
    logic signed [ID_W-1:0] run_id_reg, run_id_next;
    logic [COORD_W-1:0]     run_start_reg, run_start_next;
    logic [SIZE_W-1:0]      run_len_reg, run_len_next;
    side_t                  run_side_reg, run_side_next;
    logic                   close_pend_reg, close_pend_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;

    side_t                  iss_side;
    logic                   iss_horiz, iss_last, run_horiz;
    logic [SIZE_W-1:0]      iss_len;
    logic [COORD_W-1:0]     nb_x, nb_y, rd_x, rd_y, base_x, base_y;
    int                     rd_lin, wr_lin;
    logic [AW-1:0]          rd_addr, wr_addr;
    logic                   mem_we, issue, consume, close_fire, out_free;
    logic                   emit_edge, emit_sum;
    logic [COUNT_W:0]       count_sum;
    logic [COUNT_W-1:0]     count_sat;
    result_t                run_edge, sum_item;

    // side selection, read address and write address
    always_comb
    begin
        if (mask_reg[SIDE_TOP])
            iss_side = SIDE_TOP;
        else if (mask_reg[SIDE_BOTTOM])
            iss_side = SIDE_BOTTOM;
        else if (mask_reg[SIDE_LEFT])
            iss_side = SIDE_LEFT;
        else
            iss_side = SIDE_RIGHT;
        iss_horiz = (iss_side == SIDE_TOP) || (iss_side == SIDE_BOTTOM);
        iss_len   = iss_horiz ? cur_w_reg : cur_h_reg;
        iss_last  = ({1'b0, idx_reg} == (iss_len - SIZE_W'(1)));
        nb_x      = cur_x_reg;
        nb_y      = cur_y_reg;
        case (iss_side)
            SIDE_TOP:    nb_y = cur_y_reg - COORD_W'(1);
            SIDE_BOTTOM: nb_y = COORD_W'({1'b0, cur_y_reg} + cur_h_reg);
            SIDE_LEFT:   nb_x = cur_x_reg - COORD_W'(1);
            SIDE_RIGHT:  nb_x = COORD_W'({1'b0, cur_x_reg} + cur_w_reg);
            default: ;
        endcase
        rd_x    = iss_horiz ? nb_x + idx_reg : nb_x;
        rd_y    = iss_horiz ? nb_y : nb_y + idx_reg;
        rd_lin  = int'(rd_y) * LIM + int'(rd_x);
        rd_addr = rd_lin[AW-1:0];
        wr_lin  = int'(q_entry.pos_y) * LIM + int'(q_entry.pos_x);
        wr_addr = wr_lin[AW-1:0];
    end

    // edge of the open run, the summary beat and the saturated edge count
    always_comb
    begin
        run_horiz = (run_side_reg == SIDE_TOP) || (run_side_reg == SIDE_BOTTOM);
        base_x = (run_side_reg == SIDE_RIGHT)
               ? COORD_W'({1'b0, cur_x_reg} + cur_w_reg - SIZE_W'(1)) : cur_x_reg;
        base_y = (run_side_reg == SIDE_BOTTOM)
               ? COORD_W'({1'b0, cur_y_reg} + cur_h_reg - SIZE_W'(1)) : cur_y_reg;

        run_edge.is_summary  = 1'b0;
        run_edge.edge_x      = run_horiz ? base_x + run_start_reg : base_x;
        run_edge.edge_y      = run_horiz ? base_y : base_y + run_start_reg;
        run_edge.edge_w      = run_horiz ? run_len_reg : SIZE_W'(1);
        run_edge.edge_h      = run_horiz ? SIZE_W'(1) : run_len_reg;
        run_edge.neighbor_id = run_id_reg[NB_W-1:0];
        run_edge.first_edge  = '0;
        run_edge.edge_total  = '0;
        run_edge.last        = 1'b0;

        sum_item.is_summary  = 1'b1;
        sum_item.edge_x      = '0;
        sum_item.edge_y      = '0;
        sum_item.edge_w      = '0;
        sum_item.edge_h      = '0;
        sum_item.neighbor_id = '0;
        sum_item.first_edge  = count_reg;
        sum_item.edge_total  = total_reg;
        sum_item.last        = 1'b1;

        count_sum = {1'b0, count_reg} + (COUNT_W + 1)'(total_reg);
        count_sat = (count_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : count_sum[COUNT_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        cur_w_next      = cur_w_reg;
        cur_h_next      = cur_h_reg;
        mask_next       = mask_reg;
        idx_next        = idx_reg;
        d_valid_next    = d_valid_reg;
        d_side_next     = d_side_reg;
        d_idx_next      = d_idx_reg;
        d_last_next     = d_last_reg;
        run_id_next     = run_id_reg;
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        run_side_next   = run_side_reg;
        close_pend_next = close_pend_reg;
        total_next      = total_reg;
        count_next      = count_reg;
        out_next        = out_reg;
        out_free        = !out_valid_reg || res_ready;
        out_valid_next  = out_valid_reg && !res_ready;
        q_ready         = 1'b0;
        mem_we          = 1'b0;
        issue           = 1'b0;
        consume         = 1'b0;
        close_fire      = 1'b0;
        emit_edge       = 1'b0;
        emit_sum        = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    case (q_entry.op)
                        OP_WRITE: mem_we = 1'b1;
                        OP_CLEAR: count_next = '0;
                        OP_BUILD:
                        begin
                            cur_x_next = q_entry.pos_x;
                            cur_y_next = q_entry.pos_y;
                            cur_w_next = q_entry.width;
                            cur_h_next = q_entry.height;
                            mask_next  = q_entry.sides;
                            idx_next   = '0;
                            total_next = '0;
                            state_next = BK_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            BK_SCAN:
            begin
                close_fire = close_pend_reg && out_free;
                consume    = d_valid_reg && !close_pend_reg && out_free;
                issue      = (mask_reg != '0) && (!d_valid_reg || consume);
                if (close_fire)
                begin
                    close_pend_next = 1'b0;
                    emit_edge = !run_id_reg[ID_W-1];
                end
                if (consume)
                begin
                    if (d_idx_reg == '0)
                    begin
                        run_id_next    = rd_data_reg;
                        run_start_next = '0;
                        run_len_next   = SIZE_W'(1);
                        run_side_next  = d_side_reg;
                    end
                    else if (rd_data_reg != run_id_reg)
                    begin
                        emit_edge      = !run_id_reg[ID_W-1];
                        run_id_next    = rd_data_reg;
                        run_start_next = d_idx_reg;
                        run_len_next   = SIZE_W'(1);
                    end
                    else
                        run_len_next = run_len_reg + SIZE_W'(1);
                    if (d_last_reg)
                        close_pend_next = 1'b1;
                end
                if (issue)
                begin
                    d_side_next = iss_side;
                    d_idx_next  = idx_reg;
                    d_last_next = iss_last;
                    if (iss_last)
                    begin
                        mask_next[iss_side] = 1'b0;
                        idx_next = '0;
                    end
                    else
                        idx_next = idx_reg + COORD_W'(1);
                end
                d_valid_next = issue ? 1'b1 : (consume ? 1'b0 : d_valid_reg);
                if ((mask_reg == '0) && !d_valid_reg && !close_pend_reg)
                    state_next = BK_SUM;
            end
            BK_SUM:
            begin
                if (out_free)
                begin
                    emit_sum   = 1'b1;
                    count_next = count_sat;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase

        if (emit_edge)
        begin
            out_valid_next = 1'b1;
            out_next       = run_edge;
            total_next     = total_reg + TOTAL_W'(1);
        end
        if (emit_sum)
        begin
            out_valid_next = 1'b1;
            out_next       = sum_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            mask_reg       <= '0;
            idx_reg        <= '0;
            d_valid_reg    <= 1'b0;
            close_pend_reg <= 1'b0;
            total_reg      <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mask_reg       <= mask_next;
            idx_reg        <= idx_next;
            d_valid_reg    <= d_valid_next;
            close_pend_reg <= close_pend_next;
            total_reg      <= total_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        cur_w_reg     <= cur_w_next;
        cur_h_reg     <= cur_h_next;
        d_side_reg    <= d_side_next;
        d_idx_reg     <= d_idx_next;
        d_last_reg    <= d_last_next;
        run_id_reg    <= run_id_next;
        run_start_reg <= run_start_next;
        run_len_reg   <= run_len_next;
        run_side_reg  <= run_side_next;
        out_reg       <= out_next;
    end

    // grid memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[wr_addr] <= q_entry.value;
        if (issue)
            rd_data_reg <= grid_mem[rd_addr];
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

// ===== hw/rtl/abnr_checker.sv =====
// abnr_assertions: port-level assertions on result beats, bound to the top
// level; depends on abnr_pkg and area_border_neighbor_runs
module abnr_assertions (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           res_valid,
    input logic                           res_ready,
    input logic                           is_summary,
    input logic [abnr_pkg::COORD_W-1:0]   edge_x,
    input logic [abnr_pkg::COORD_W-1:0]   edge_y,
    input logic [abnr_pkg::SIZE_W-1:0]    edge_w,
    input logic [abnr_pkg::SIZE_W-1:0]    edge_h,
    input logic [abnr_pkg::NB_W-1:0]      neighbor_id,
    input logic [abnr_pkg::COUNT_W-1:0]   first_edge,
    input logic [abnr_pkg::TOTAL_W-1:0]   edge_total,
    input logic                           last
);
    import abnr_pkg::*;

    localparam logic [TOTAL_W-1:0] MAX_EDGES = TOTAL_W'(4 * FIELD_LIMIT - 8);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable({is_summary, edge_x, edge_y,
            edge_w, edge_h, neighbor_id, first_edge, edge_total, last}))
        else $error("result beat changed while stalled");

    a_last_is_summary: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (last == is_summary))
        else $error("last and summary flag disagree");

    a_edge_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !is_summary |-> (edge_w == SIZE_W'(1) || edge_h == SIZE_W'(1))
            && edge_w != '0 && edge_h != '0 && first_edge == '0 && edge_total == '0)
        else $error("edge beat is not a one-cell-thick strip");

    a_summary_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && is_summary |-> edge_total <= MAX_EDGES && edge_w == '0
            && edge_h == '0 && edge_x == '0 && edge_y == '0 && neighbor_id == '0)
        else $error("summary beat malformed");

endmodule

bind area_border_neighbor_runs abnr_assertions u_abnr_assertions (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result_ch.valid),
    .res_ready   (result_ch.ready),
    .is_summary  (result_ch.is_summary),
    .edge_x      (result_ch.edge_x),
    .edge_y      (result_ch.edge_y),
    .edge_w      (result_ch.edge_w),
    .edge_h      (result_ch.edge_h),
    .neighbor_id (result_ch.neighbor_id),
    .first_edge  (result_ch.first_edge),
    .edge_total  (result_ch.edge_total),
    .last        (result_ch.last)
);
